/* rtl/rwm_pkg.sv */
// Package for the RGB window median block: sizes, payload types, control types and the window capacity function.
package rwm_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int MAX_RADIUS = 3;
	localparam int RADIUS_W = 2;
	localparam int WIN_SIDE_MAX = 2 * MAX_RADIUS + 1;
	localparam int WIN_DEPTH = WIN_SIDE_MAX * WIN_SIDE_MAX;
	localparam int CNT_W = $clog2(WIN_DEPTH + 1);
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
		logic                    last;
	} sample_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] median_red;
		logic [CHANNEL_BITS-1:0] median_green;
		logic [CHANNEL_BITS-1:0] median_blue;
		logic [CNT_W-1:0]        sample_count;
		logic                    overflow;
	} result_t;

	typedef struct packed {
		logic insert;
		logic load_rem;
		logic shift;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rem_zero;
	} dp_status_t;

	function automatic logic [CNT_W-1:0] capacity(input logic [RADIUS_W-1:0] radius);
		int r;
		int side;
		r = int'(radius);
		if (r > MAX_RADIUS) begin
			r = MAX_RADIUS;
		end
		side = 2 * r + 1;
		return CNT_W'(side * side);
	endfunction

endpackage

/* rtl/rgb_window_median.sv */
// Top level of the RGB window median block.
// Usage: the sender presents one neighbour sample on sample and raises start; the
// transfer happens at a rising edge with start high and busy low. The sample that
// carries last closes the window. Samples without last are taken one per cycle.
// After the closing transfer busy stays high while the three sorted register
// chains shift down one place per cycle until the median of the stored samples
// sits at the head. The result is then registered on result with done high for
// a single cycle; the receiver cannot hold it off, and a new sample may be
// transferred in that same cycle.
// Samples beyond (2r+1)^2 are dropped and flagged in result.overflow.
// The radius register is written through cfg_valid and cfg_data; cfg_ready is
// always high and a write should only be made while the block is idle.
// After reset the radius is 1, the window is empty and busy is low.
module rgb_window_median (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  rwm_pkg::sample_t             sample,
	output logic                         done,
	output rwm_pkg::result_t             result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rwm_pkg::RADIUS_W-1:0] cfg_data
);

	rwm_pkg::ctrl_cmd_t  cmd;
	rwm_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	rwm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (sample.last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rwm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

/* rtl/rwm_sort_chain.sv */
// Sorted register chain for one channel: insertion of one sample per cycle and shift-down readout.
module rwm_sort_chain (
	input  logic                              clk,
	input  logic                              insert,
	input  logic                              shift,
	input  logic [rwm_pkg::CNT_W-1:0]         fill,
	input  logic [rwm_pkg::CHANNEL_BITS-1:0]  din,
	output logic [rwm_pkg::CHANNEL_BITS-1:0]  head
);

	localparam int Depth = rwm_pkg::WIN_DEPTH;

	logic [rwm_pkg::CHANNEL_BITS-1:0] cell_q [Depth];
	logic [Depth-1:0] above;
	logic [Depth-1:0] at_end;

	always_comb begin
		for (int i = 0; i < Depth; i++) begin
			above[i] = (rwm_pkg::CNT_W'(i) < fill) && (cell_q[i] > din);
			at_end[i] = (rwm_pkg::CNT_W'(i) == fill);
		end
	end

	for (genvar g = 0; g < Depth; g++) begin : g_cell
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (insert) begin
					if (above[0] || at_end[0]) begin
						cell_q[0] <= din;
					end
				end else if (shift) begin
					cell_q[0] <= cell_q[1];
				end
			end
		end else if (g == Depth - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (insert) begin
					if (above[g-1]) begin
						cell_q[g] <= cell_q[g-1];
					end else if (above[g] || at_end[g]) begin
						cell_q[g] <= din;
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (insert) begin
					if (above[g-1]) begin
						cell_q[g] <= cell_q[g-1];
					end else if (above[g] || at_end[g]) begin
						cell_q[g] <= din;
					end
				end else if (shift) begin
					cell_q[g] <= cell_q[g+1];
				end
			end
		end
	end

	assign head = cell_q[0];

endmodule

/* rtl/rwm_datapath.sv */
// Datapath: radius register, fill and overflow tracking, three sorted chains and the result register.
module rwm_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [rwm_pkg::RADIUS_W-1:0]      cfg_data,
	input  rwm_pkg::sample_t                  sample,
	input  rwm_pkg::ctrl_cmd_t                cmd,
	output rwm_pkg::dp_status_t               status,
	output rwm_pkg::result_t                  result
);

	logic [rwm_pkg::RADIUS_W-1:0]     radius_q;
	logic [rwm_pkg::CNT_W-1:0]        fill_q;
	logic [rwm_pkg::CNT_W-1:0]        fill_next;
	logic [rwm_pkg::CNT_W-1:0]        rem_q;
	logic [rwm_pkg::CNT_W-1:0]        cap;
	logic                             drop_q;
	logic                             room;
	logic                             store;
	logic [rwm_pkg::CHANNEL_BITS-1:0] red_head;
	logic [rwm_pkg::CHANNEL_BITS-1:0] green_head;
	logic [rwm_pkg::CHANNEL_BITS-1:0] blue_head;
	rwm_pkg::result_t                 result_q;

	assign cap = rwm_pkg::capacity(radius_q);
	assign room = fill_q < cap;
	assign store = cmd.insert && room;
	assign fill_next = fill_q + rwm_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= rwm_pkg::RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			drop_q <= 1'b0;
			rem_q <= '0;
		end else if (cmd.emit) begin
			fill_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.insert) begin
			if (room) begin
				fill_q <= fill_next;
			end else begin
				drop_q <= 1'b1;
			end
			if (cmd.load_rem) begin
				rem_q <= room ? (fill_next >> 1) : (fill_q >> 1);
			end
		end else if (cmd.shift) begin
			rem_q <= rem_q - rwm_pkg::CNT_W'(1);
		end
	end

	rwm_sort_chain u_red (
		.clk    (clk),
		.insert (store),
		.shift  (cmd.shift),
		.fill   (fill_q),
		.din    (sample.red),
		.head   (red_head)
	);

	rwm_sort_chain u_green (
		.clk    (clk),
		.insert (store),
		.shift  (cmd.shift),
		.fill   (fill_q),
		.din    (sample.green),
		.head   (green_head)
	);

	rwm_sort_chain u_blue (
		.clk    (clk),
		.insert (store),
		.shift  (cmd.shift),
		.fill   (fill_q),
		.din    (sample.blue),
		.head   (blue_head)
	);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.median_red <= red_head;
			result_q.median_green <= green_head;
			result_q.median_blue <= blue_head;
			result_q.sample_count <= fill_q;
			result_q.overflow <= drop_q;
		end
	end

	assign status.rem_zero = (rem_q == '0);
	assign result = result_q;

endmodule

/* rtl/rwm_ctrl.sv */
// Controller: accepts samples, runs the readout shift after the closing sample and strobes the result.
module rwm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                last,
	input  rwm_pkg::dp_status_t status,
	output rwm_pkg::ctrl_cmd_t  cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic {
		ST_IDLE,
		ST_READOUT
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q == ST_READOUT);
	assign done = done_q;

	always_comb begin
		cmd.insert = accept;
		cmd.load_rem = accept && last;
		cmd.shift = (state_q == ST_READOUT) && !status.rem_zero;
		cmd.emit = (state_q == ST_READOUT) && status.rem_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && last) begin
						state_q <= ST_READOUT;
					end
				end
				ST_READOUT: begin
					if (status.rem_zero) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while readout still running");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last))
		else $error("readout began without a closing sample transfer");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_READOUT && status.rem_zero))
		else $error("result strobe without a finished readout");

endmodule

/* bench/tb.sv */
// Testbench for rgb_window_median: a scoreboard class predicts and checks each window result.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	typedef logic [rwm_pkg::CHANNEL_BITS-1:0] chan_t;

	typedef enum int {
		MODE_RANDOM,
		MODE_CLUSTER,
		MODE_EXTREME
	} value_mode_t;

	class median_scoreboard;
		chan_t reds[$];
		chan_t greens[$];
		chan_t blues[$];
		bit dropped;
		logic [rwm_pkg::RADIUS_W-1:0] radius;
		rwm_pkg::result_t medians_due[$];
		int errors;

		function new();
			radius = rwm_pkg::RADIUS_RESET;
			dropped = 1'b0;
			errors = 0;
		endfunction

		function void set_radius(input logic [rwm_pkg::RADIUS_W-1:0] value);
			radius = value;
		endfunction

		function int window_capacity();
			int r;
			r = int'(radius);
			if (r > rwm_pkg::MAX_RADIUS) begin
				r = rwm_pkg::MAX_RADIUS;
			end
			return (2 * r + 1) * (2 * r + 1);
		endfunction

		function void insert_ordered(ref chan_t q[$], input chan_t value);
			int pos;
			pos = q.size();
			while (pos > 0 && q[pos-1] > value) begin
				pos--;
			end
			q.insert(pos, value);
		endfunction

		function int pending();
			return medians_due.size();
		endfunction

		// Called for every accepted input transfer.
		function void note_sample(input rwm_pkg::sample_t s);
			rwm_pkg::result_t due;
			int n;
			n = reds.size();
			if (n < window_capacity() && n < rwm_pkg::WIN_DEPTH) begin
				insert_ordered(reds, s.red);
				insert_ordered(greens, s.green);
				insert_ordered(blues, s.blue);
			end else begin
				dropped = 1'b1;
			end
			if (s.last) begin
				n = reds.size();
				due.median_red = reds[n/2];
				due.median_green = greens[n/2];
				due.median_blue = blues[n/2];
				due.sample_count = rwm_pkg::CNT_W'(n);
				due.overflow = dropped;
				medians_due = {medians_due, due};
				reds.delete();
				greens.delete();
				blues.delete();
				dropped = 1'b0;
			end
		endfunction

		function void check_result(input rwm_pkg::result_t got);
			rwm_pkg::result_t due;
			if (medians_due.size() == 0) begin
				$error("result transfer with no median expected");
				errors++;
				return;
			end
			due = medians_due.pop_front();
			if (got.median_red !== due.median_red) begin
				$error("median_red: expected %0d, got %0d", due.median_red, got.median_red);
				errors++;
			end
			if (got.median_green !== due.median_green) begin
				$error("median_green: expected %0d, got %0d", due.median_green, got.median_green);
				errors++;
			end
			if (got.median_blue !== due.median_blue) begin
				$error("median_blue: expected %0d, got %0d", due.median_blue, got.median_blue);
				errors++;
			end
			if (got.sample_count !== due.sample_count) begin
				$error("sample_count: expected %0d, got %0d", due.sample_count, got.sample_count);
				errors++;
			end
			if (got.overflow !== due.overflow) begin
				$error("overflow: expected %0d, got %0d", due.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	rwm_pkg::sample_t sample;
	logic done;
	rwm_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [rwm_pkg::RADIUS_W-1:0] cfg_data;

	median_scoreboard board = new();
	int idle_pct;
	int cycles = 0;

	rgb_window_median DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				board.check_result(result);
			end
			if (start && !busy) begin
				board.note_sample(sample);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic rwm_pkg::sample_t pixel(input chan_t r, input chan_t g, input chan_t b,
			input logic last_flag);
		rwm_pkg::sample_t s;
		s.red = r;
		s.green = g;
		s.blue = b;
		s.last = last_flag;
		return s;
	endfunction

	function automatic chan_t channel_value(input value_mode_t mode, input chan_t base);
		unique case (mode)
			MODE_RANDOM: begin
				return chan_t'($urandom);
			end
			MODE_CLUSTER: begin
				return base + chan_t'($urandom_range(7));
			end
			default: begin
				return $urandom_range(1) ? '1 : '0;
			end
		endcase
	endfunction

	task automatic send_sample(input rwm_pkg::sample_t s);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (board.pending() != 0 || busy) begin
			@(negedge clk);
		end
		repeat (30) @(negedge clk);
	endtask

	task automatic set_radius(input logic [rwm_pkg::RADIUS_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_radius(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_window(input int count);
		value_mode_t mode;
		chan_t base_r;
		chan_t base_g;
		chan_t base_b;
		if ($urandom_range(9) < 6) begin
			mode = MODE_RANDOM;
		end else if ($urandom_range(1) != 0) begin
			mode = MODE_CLUSTER;
		end else begin
			mode = MODE_EXTREME;
		end
		base_r = chan_t'($urandom);
		base_g = chan_t'($urandom);
		base_b = chan_t'($urandom);
		for (int i = 0; i < count; i++) begin
			send_sample(pixel(channel_value(mode, base_r), channel_value(mode, base_g),
				channel_value(mode, base_b), i == count - 1));
		end
	endtask

	task automatic run_windows(input int items);
		int sent;
		int count;
		int cap;
		int side;
		int r;
		int pick;
		sent = 0;
		r = int'(board.radius);
		side = 2 * r + 1;
		cap = side * side;
		while (sent < items) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				count = cap;
			end else if (pick < 45) begin
				count = side * (r + 1);
			end else if (pick < 55) begin
				count = (r + 1) * (r + 1);
			end else if (pick < 75) begin
				count = $urandom_range(cap, 1);
			end else if (pick < 90) begin
				count = cap + $urandom_range(4, 1);
			end else begin
				count = $urandom_range(cap + 3, 1);
			end
			send_window(count);
			sent += count;
		end
	endtask

	initial begin
		logic [rwm_pkg::RADIUS_W-1:0] r;
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_radius(rwm_pkg::RADIUS_W'(0));
		send_sample(pixel('1, '0, '1, 1'b1));
		send_sample(pixel('0, '1, '0, 1'b0));
		send_sample(pixel('1, '0, 8'h55, 1'b1));
		set_radius(rwm_pkg::RADIUS_W'(1));
		send_sample(pixel('0, '1, 8'd17, 1'b0));
		send_sample(pixel('1, '0, 8'd200, 1'b1));
		// Shrink the window while it holds four samples; the closing sample is dropped.
		send_sample(pixel(8'd10, 8'd20, 8'd30, 1'b0));
		send_sample(pixel(8'd40, 8'd5, 8'd250, 1'b0));
		send_sample(pixel(8'd7, 8'd99, 8'd1, 1'b0));
		send_sample(pixel(8'd128, 8'd128, 8'd128, 1'b0));
		set_radius(rwm_pkg::RADIUS_W'(0));
		send_sample(pixel('1, '1, '1, 1'b1));
		set_radius(rwm_pkg::RADIUS_W'(3));
		send_sample(pixel('0, '1, 8'h55, 1'b0));
		send_sample(pixel('1, '0, 8'hAA, 1'b0));
		send_sample(pixel(8'h55, 8'hAA, '0, 1'b0));
		send_sample(pixel(8'hAA, 8'h55, '1, 1'b0));
		send_sample(pixel(8'h80, 8'h7F, 8'h01, 1'b0));
		send_sample(pixel(8'h7F, 8'h80, 8'hFE, 1'b0));
		send_sample(pixel(8'h01, 8'hFE, 8'h80, 1'b0));
		send_sample(pixel(8'hFE, 8'h01, 8'h7F, 1'b0));
		send_sample(pixel('0, '0, '0, 1'b0));
		send_sample(pixel('1, '1, '1, 1'b1));

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 8 : (phase == 1) ? 49 : 0;
			for (int k = 0; k < 5; k++) begin
				r = (k == 0) ? rwm_pkg::RADIUS_W'(0) : (k == 1) ? rwm_pkg::RADIUS_W'(3) :
					rwm_pkg::RADIUS_W'($urandom_range(3));
				set_radius(r);
				run_windows(100);
			end
		end

		wait_idle();
		if (board.pending() != 0) begin
			$error("%0d medians never arrived", board.pending());
			board.errors++;
		end
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
